// ===== sv/rbi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbi_pkg
// Shared types, constants and helpers for the rigid body integrator.
// ----------------------------------------------------------------------------
package rbi_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int WIDE_WIDTH = 2 * WORD_WIDTH;

    localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    typedef logic signed [WORD_WIDTH-1:0] word_t;

    typedef enum logic [2:0]
    {
        MODE_STEP   = 3'd0,
        MODE_FORCE  = 3'd1,
        MODE_ACCEL  = 3'd2,
        MODE_IMPULSE = 3'd3,
        MODE_ENERGY = 3'd4
    } mode_t;

    // Saturate a signed wide value to the word.
    function automatic word_t sat_wide(input logic signed [WIDE_WIDTH+1:0] v);
        word_t r;
        if (v > $signed({{(WIDE_WIDTH+2-WORD_WIDTH){1'b0}}, WORD_MAX}))
            r = WORD_MAX;
        else if (v < $signed({{(WIDE_WIDTH+2-WORD_WIDTH){1'b1}}, WORD_MIN}))
            r = WORD_MIN;
        else
            r = v[WORD_WIDTH-1:0];
        return r;
    endfunction

    // Saturating add of two words.
    function automatic word_t sat_add(input word_t a, input word_t b);
        logic signed [WORD_WIDTH:0] s;
        word_t r;
        s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
        if (s[WORD_WIDTH] != s[WORD_WIDTH-1])
            r = s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
        else
            r = s[WORD_WIDTH-1:0];
        return r;
    endfunction

endpackage

// ===== sv/rbi_divsqrt.sv =====
// ----------------------------------------------------------------------------
// rbi_divsqrt
// Bit-serial divider by mass, and restoring square root, one bit per cycle.
// ----------------------------------------------------------------------------
module rbi_divsqrt
    import rbi_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic                    is_sqrt,
    input  logic [WIDE_WIDTH+8:0]   num,
    input  logic [30:0]             divisor,
    output logic                    done,
    output logic [WIDE_WIDTH+8:0]   result
);

    localparam int NW = WIDE_WIDTH + 9;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [NW-1:0] quo_reg;
    logic [NW:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          sqrt_reg;
    logic [30:0]   div_reg;

    logic [NW:0]   rem_shift;
    logic [NW:0]   trial;
    logic          fits;

    // Root digit step takes two numerator bits; divide takes one.
    always_comb
    begin
        if (sqrt_reg)
        begin
            rem_shift = {rem_reg[NW-2:0], num_reg[NW-1:NW-2]};
            trial     = {quo_reg[NW-2:0], 2'b01};
        end
        else
        begin
            rem_shift = {rem_reg[NW-1:0], num_reg[NW-1]};
            trial     = {{(NW-30){1'b0}}, div_reg};
        end
        fits = rem_shift >= trial;
    end

    // Advance one quotient or root bit per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= is_sqrt ? CW'(NW / 2) : CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    // Align the radicand so its bit pairs end at bit zero; its top bit is always clear.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg  <= is_sqrt ? {num[NW-2:0], 1'b0} : num;
            quo_reg  <= '0;
            rem_reg  <= '0;
            sqrt_reg <= is_sqrt;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            num_reg <= sqrt_reg ? {num_reg[NW-3:0], 2'b00} : {num_reg[NW-2:0], 1'b0};
            rem_reg <= fits ? rem_shift - trial : rem_shift;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign result = quo_reg;

endmodule

// ===== sv/rigid_body_integrator.sv =====
// ----------------------------------------------------------------------------
// rigid_body_integrator
// Kinematic integration of one rigid body in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Unused modes and zero energy pass from the scaling step straight to the output.
// Energy runs a 73-bit division and then a square root; force and impulse run one
// 73-bit bit-serial division per component. Zero-mass energy skips both.
// One item at a time: s_tready is low until the result is taken.
// Reset clears position, velocity and acceleration to zero and mass to 1.0.
module rigid_body_integrator
    import rbi_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         mass_we,
    input  logic [30:0]  mass_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: mode[2:0], vec_x[34:3], vec_y[66:35], vec_z[98:67], scale[130:99],
    //        step_time[161:131], energy[193:162], zero fill to 200
    input  logic [199:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64]
    output logic [95:0]  m_tdata
);

    localparam int NW = WIDE_WIDTH + 9;

    typedef enum logic [7:0]
    {
        ST_IDLE  = 8'b00000001,
        ST_SCALE = 8'b00000010,
        ST_DIV   = 8'b00000100,
        ST_DWAIT = 8'b00001000,
        ST_MUL   = 8'b00010000,
        ST_APPLY = 8'b00100000,
        ST_ROOT  = 8'b01000000,
        ST_OUT   = 8'b10000000
    } state_t;

    state_t state_reg;
    logic [30:0] mass_reg;
    word_t pos_reg [3];
    word_t vel_reg [3];
    word_t acc_reg [3];
    word_t v_reg [3];
    word_t q_reg;
    word_t spd_reg;
    logic [2:0]  mode_reg;
    word_t vin_reg [3];
    word_t scale_reg;
    logic [30:0] dt_reg;
    word_t dt2_reg;
    word_t en_reg;
    logic [1:0]  idx_reg;
    logic [2:0]  sub_reg;

    // Shared multiplier: sat(floor(a*b / 2^sh)).
    word_t mul_a, mul_b;
    logic  mul_sh1;
    logic signed [WIDE_WIDTH-1:0] prod;
    logic signed [WIDE_WIDTH+1:0] shifted;
    word_t mul_q;

    always_comb
    begin
        prod = mul_a * mul_b;
        if (mul_sh1)
            shifted = $signed({{2{prod[WIDE_WIDTH-1]}}, prod}) >>> (FRAC_BITS + 1);
        else
            shifted = $signed({{2{prod[WIDE_WIDTH-1]}}, prod}) >>> FRAC_BITS;
        mul_q = sat_wide(shifted);
    end

    // Divider / root unit.
    logic du_start, du_sqrt, du_done;
    logic [NW-1:0] du_num, du_res;
    word_t div_in;
    logic [WORD_WIDTH:0] div_mag;
    word_t div_q;

    rbi_divsqrt u_divsqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (du_start),
        .is_sqrt (du_sqrt),
        .num     (du_num),
        .divisor (mass_reg),
        .done    (du_done),
        .result  (du_res)
    );

    always_comb
    begin
        div_in = v_reg[idx_reg];
        div_mag = div_in[WORD_WIDTH-1] ? -{1'b1, div_in} : {1'b0, div_in};
        if (du_res > NW'(WORD_MAX) + NW'(div_in[WORD_WIDTH-1]))
            div_q = div_in[WORD_WIDTH-1] ? WORD_MIN : WORD_MAX;
        else
            div_q = div_in[WORD_WIDTH-1] ? -du_res[WORD_WIDTH-1:0] : du_res[WORD_WIDTH-1:0];
    end

    logic [WORD_WIDTH:0] en_mag;
    assign en_mag = en_reg[WORD_WIDTH-1] ? -{1'b1, en_reg} : {1'b0, en_reg};

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        mul_sh1 = 1'b0;
        unique case (state_reg)
            ST_SCALE:
            begin
                if (idx_reg == 2'd3)
                begin
                    mul_a = {1'b0, dt_reg};
                    mul_b = {1'b0, dt_reg};
                end
                else
                begin
                    mul_a = vin_reg[idx_reg];
                    mul_b = scale_reg;
                end
            end
            ST_MUL:
            begin
                unique case (sub_reg)
                    3'd0:
                    begin
                        mul_a = vel_reg[idx_reg];
                        mul_b = {1'b0, dt_reg};
                    end
                    3'd1:
                    begin
                        mul_a = acc_reg[idx_reg];
                        mul_b = dt2_reg;
                        mul_sh1 = 1'b1;
                    end
                    3'd2:
                    begin
                        mul_a = acc_reg[idx_reg];
                        mul_b = {1'b0, dt_reg};
                    end
                    3'd3:
                    begin
                        mul_a = q_reg;
                        mul_b = {1'b0, dt_reg};
                    end
                    default:
                    begin
                        mul_a = v_reg[idx_reg];
                        mul_b = spd_reg;
                    end
                endcase
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign du_sqrt = (state_reg == ST_DIV) && (sub_reg == 3'd1);
    assign du_num = (sub_reg == 3'd1) ? du_res :
                    ((mode_reg == MODE_ENERGY) ? (NW'({en_mag, 1'b0}) << (2 * FRAC_BITS))
                                               : (NW'(div_mag) << FRAC_BITS));
    assign du_start = (state_reg == ST_DIV);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {pos_reg[2], pos_reg[1], pos_reg[0]};

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mass_reg  <= 31'd65536;
            idx_reg   <= '0;
            sub_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
                acc_reg[i] <= '0;
            end
        end
        else
        begin
            if (mass_we)
                mass_reg <= mass_wdata;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        mode_reg   <= s_tdata[2:0];
                        vin_reg[0] <= s_tdata[34:3];
                        vin_reg[1] <= s_tdata[66:35];
                        vin_reg[2] <= s_tdata[98:67];
                        scale_reg  <= s_tdata[130:99];
                        dt_reg     <= s_tdata[161:131];
                        en_reg     <= s_tdata[193:162];
                        idx_reg    <= '0;
                        sub_reg    <= '0;
                        state_reg  <= ST_SCALE;
                    end
                end
                ST_SCALE:
                begin
                    if (idx_reg == 2'd3)
                    begin
                        dt2_reg <= mul_q;
                        idx_reg <= '0;
                        priority if (mode_reg == MODE_STEP)
                        begin
                            sub_reg <= 3'd0;
                            state_reg <= ST_MUL;
                        end
                        else if (mode_reg == MODE_ACCEL)
                            state_reg <= ST_APPLY;
                        else if (mode_reg == MODE_FORCE || mode_reg == MODE_IMPULSE)
                            state_reg <= ST_DIV;
                        else if (mode_reg == MODE_ENERGY && en_reg != '0)
                        begin
                            if (mass_reg == '0)
                            begin
                                spd_reg <= en_reg[WORD_WIDTH-1] ? -WORD_MAX : WORD_MAX;
                                sub_reg <= 3'd4;
                                state_reg <= ST_MUL;
                            end
                            else
                                state_reg <= ST_DIV;
                        end
                        else
                            state_reg <= ST_OUT;
                    end
                    else
                    begin
                        v_reg[idx_reg] <= mul_q;
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_DIV:
                    state_reg <= ST_DWAIT;
                ST_DWAIT:
                begin
                    if (du_done)
                    begin
                        if (mode_reg == MODE_ENERGY)
                        begin
                            if (sub_reg == 3'd0)
                            begin
                                sub_reg <= 3'd1;
                                state_reg <= ST_DIV;
                            end
                            else
                            begin
                                spd_reg <= (du_res > NW'(WORD_MAX))
                                    ? (en_reg[WORD_WIDTH-1] ? -WORD_MAX : WORD_MAX)
                                    : (en_reg[WORD_WIDTH-1] ? -du_res[WORD_WIDTH-1:0]
                                                            : du_res[WORD_WIDTH-1:0]);
                                sub_reg <= 3'd4;
                                state_reg <= ST_MUL;
                            end
                        end
                        else
                        begin
                            q_reg <= (div_in == '0) ? '0 : div_q;
                            state_reg <= ST_APPLY;
                        end
                    end
                end
                ST_APPLY:
                begin
                    priority if (mode_reg == MODE_ACCEL)
                    begin
                        acc_reg[idx_reg] <= sat_add(acc_reg[idx_reg], v_reg[idx_reg]);
                        if (idx_reg == 2'd2)
                            state_reg <= ST_OUT;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                    else if (mode_reg == MODE_FORCE)
                    begin
                        acc_reg[idx_reg] <= sat_add(acc_reg[idx_reg], q_reg);
                        if (idx_reg == 2'd2)
                            state_reg <= ST_OUT;
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= ST_DIV;
                        end
                    end
                    else
                    begin
                        sub_reg <= 3'd3;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    unique case (sub_reg)
                        3'd0:
                        begin
                            pos_reg[idx_reg] <= sat_add(pos_reg[idx_reg], mul_q);
                            sub_reg <= 3'd1;
                        end
                        3'd1:
                        begin
                            pos_reg[idx_reg] <= sat_add(pos_reg[idx_reg], mul_q);
                            sub_reg <= 3'd2;
                        end
                        3'd2:
                        begin
                            vel_reg[idx_reg] <= sat_add(vel_reg[idx_reg], mul_q);
                            sub_reg <= 3'd0;
                            if (idx_reg == 2'd2)
                                state_reg <= ST_OUT;
                            else
                                idx_reg <= idx_reg + 1'b1;
                        end
                        3'd3:
                        begin
                            vel_reg[idx_reg] <= sat_add(vel_reg[idx_reg], mul_q);
                            if (idx_reg == 2'd2)
                                state_reg <= ST_OUT;
                            else
                            begin
                                idx_reg <= idx_reg + 1'b1;
                                state_reg <= ST_DIV;
                            end
                        end
                        default:
                        begin
                            vel_reg[idx_reg] <= sat_add(vel_reg[idx_reg], mul_q);
                            if (idx_reg == 2'd2)
                                state_reg <= ST_OUT;
                            else
                                idx_reg <= idx_reg + 1'b1;
                        end
                    endcase
                end
                ST_ROOT:
                    state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (m_tready)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/rbi_checker.sv =====
// ----------------------------------------------------------------------------
// rbi_checker
// Port-level checks for the rigid body integrator, bound to the top level.
// ----------------------------------------------------------------------------
module rbi_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // Never ready for input while a result is pending.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // A taken input blocks the input side next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready right after accept");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped or changed under stall");

endmodule

bind rigid_body_integrator rbi_checker u_rbi_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
